// ----- rtl/core/spne_pkg.sv -----
package spne_pkg;

    // block size
    localparam int CHANNELS    = 16;
    localparam int HOLD_DEPTH  = 32;

    // field widths
    localparam int STATUS_W    = 8;
    localparam int DATA_W      = 7;
    localparam int TICK_W      = 32;
    localparam int THR_W       = 7;
    localparam int ENTRY_W     = STATUS_W + 2 * DATA_W;
    localparam int FIELDS_W    = ENTRY_W + TICK_W;
    localparam int TDATA_W     = ((FIELDS_W + 7) / 8) * 8;

    // derived widths
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W       = $clog2(HOLD_DEPTH + 1);
    localparam int IDX_W       = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int STORE_DEPTH = CHANNELS * HOLD_DEPTH;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // command queue between front and back
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int PEND_W      = $clog2(QDEPTH + 2);

    // message codes
    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_CTRL     = 4'hB;
    localparam logic [3:0] KIND_SYSTEM   = 4'hF;
    localparam logic [DATA_W-1:0] SUSTAIN_CC = 7'd64;
    localparam logic [THR_W-1:0]  THR_RESET  = 7'd64;
    localparam logic [4:0]        CH_LIMIT   = 5'(CHANNELS);

    typedef enum logic {
        CMD_PASS,
        CMD_DRAIN
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind             kind;
        logic [STATUS_W-1:0]   status;
        logic [DATA_W-1:0]     data_one;
        logic [DATA_W-1:0]     data_two;
        logic [TICK_W-1:0]     tick;
        logic                  ovf;
        logic [CNT_W-1:0]      count;
        logic [CH_W-1:0]       ch;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_DATA
    } t_back_state;

    // hold store address of one channel's slot
    function automatic logic [ADDR_W-1:0] store_addr(input logic [CH_W-1:0] ch,
                                                     input logic [IDX_W-1:0] idx);
        store_addr = ADDR_W'(ch) * ADDR_W'(HOLD_DEPTH) + ADDR_W'(idx);
    endfunction

endpackage

// ----- rtl/core/sustain_pedal_note_extender_core.sv -----
// Sustain pedal note extender. MIDI channel events enter on the slave stream in time
// order; per channel a pedal flag and a hold store of up to HOLD_DEPTH note-offs are
// kept. Sustain-on (controller 64 at or above the threshold register) sets the flag
// and is dropped; a note-off on a pedal-down channel is held; sustain-off clears the
// flag, is dropped and releases the held note-offs in arrival order with the
// sustain-off's tick, tlast on the final one. A note-off meeting a full store passes
// at once with tuser (overflow) set. Everything else passes unchanged with tlast set.
// Timing: a dropped or held transaction is taken by the front alone; a passed one
// goes through the command queue to the output register. A release takes the
// command in BK_IDLE, then passes BK_READ and BK_DATA for each entry, as the
// 512 x 22 hold store has a registered read port; BK_DATA waits while the output
// register is full. The store needs no clearing pass after reset, and a note-off
// that would be stored waits while any release is still queued or running.
module sustain_pedal_note_extender_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // status_byte[7:0], data_one[14:8], data_two[21:15], event_tick[53:22], zero[55:54]
    input  logic [55:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_status[7:0], out_data_one[14:8], out_data_two[21:15], out_tick[53:22],
    // zero[55:54]
    output logic [55:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    // held_overflow[0]
    output logic        o_m_axis_tuser
);
    import spne_pkg::*;

    t_cmd                q_in_cmd;
    t_cmd                q_out_cmd;
    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    logic                drain_done;
    logic                st_we;
    logic [ADDR_W-1:0]   st_waddr;
    logic [ENTRY_W-1:0]  st_wdata;
    logic [ADDR_W-1:0]   st_raddr;
    logic [ENTRY_W-1:0]  st_rdata;
    logic [PEND_W-1:0]   pending;
    logic [STATUS_W-1:0] m_status;
    logic [DATA_W-1:0]   m_d1;
    logic [DATA_W-1:0]   m_d2;
    logic [TICK_W-1:0]   m_tick;

    // classify and update channel state
    spne_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_status     (i_s_axis_tdata[7:0]),
        .i_data_one   (i_s_axis_tdata[14:8]),
        .i_data_two   (i_s_axis_tdata[21:15]),
        .i_tick       (i_s_axis_tdata[53:22]),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_cmd      (q_in_cmd),
        .i_drain_done (drain_done),
        .o_st_we      (st_we),
        .o_st_addr    (st_waddr),
        .o_st_wdata   (st_wdata),
        .o_pending    (pending)
    );

    // command queue
    spne_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_out_cmd),
        .o_empty (q_empty)
    );

    // hold store
    spne_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // pass-through and release
    spne_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_cmd      (q_out_cmd),
        .o_q_pop      (q_pop),
        .o_rd_addr    (st_raddr),
        .i_rd_data    (st_rdata),
        .o_drain_done (drain_done),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_status     (m_status),
        .o_data_one   (m_d1),
        .o_data_two   (m_d2),
        .o_tick       (m_tick),
        .o_ovf        (o_m_axis_tuser),
        .o_last       (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {(TDATA_W - FIELDS_W)'(0), m_tick, m_d2, m_d1, m_status};

`ifndef SYNTHESIS
    // a hold-store write never races a release still being read out
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_we |-> (pending == '0))
        else $error("hold store written while a release is pending");

    // a finished release always had a pending count behind it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        drain_done |-> (pending != '0))
        else $error("release finished with no release pending");

    // an overflow note-off is always a single-result run
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("overflow result without tlast");

    // the pending count follows each queued release
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && (q_in_cmd.kind == CMD_DRAIN) && !drain_done)
        |=> (pending == $past(pending) + 1'b1))
        else $error("pending release count did not advance");
`endif

endmodule

// ----- rtl/core/spne_ram.sv -----
module spne_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/spne_front.sv -----
module spne_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [spne_pkg::THR_W-1:0]    i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [spne_pkg::STATUS_W-1:0] i_status,
    input  logic [spne_pkg::DATA_W-1:0]   i_data_one,
    input  logic [spne_pkg::DATA_W-1:0]   i_data_two,
    input  logic [spne_pkg::TICK_W-1:0]   i_tick,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output spne_pkg::t_cmd                o_q_cmd,
    input  logic                          i_drain_done,
    output logic                          o_st_we,
    output logic [spne_pkg::ADDR_W-1:0]   o_st_addr,
    output logic [spne_pkg::ENTRY_W-1:0]  o_st_wdata,
    output logic [spne_pkg::PEND_W-1:0]   o_pending
);
    import spne_pkg::*;

    logic [THR_W-1:0]    r_thr;
    logic [CHANNELS-1:0] r_pedal;
    logic [CNT_W-1:0]    r_count [CHANNELS];
    logic [PEND_W-1:0]   r_pending;
    logic [PEND_W-1:0]   n_pending;

    logic [3:0]       kind;
    logic [CH_W-1:0]  ch;
    logic             chan_ok;
    logic             is_sus;
    logic             sus_on;
    logic             sus_off;
    logic             is_off;
    logic [CNT_W-1:0] cur_cnt;
    logic             full;
    logic             held_off;
    logic             do_hold;
    logic             do_drain;
    logic             emit;
    logic             accept;

    // classify the incoming transaction
    always_comb begin
        kind     = i_status[7:4];
        ch       = i_status[CH_W-1:0];
        chan_ok  = (kind >= KIND_NOTE_OFF) && (kind != KIND_SYSTEM)
                   && ({1'b0, i_status[3:0]} < CH_LIMIT);
        is_sus   = chan_ok && (kind == KIND_CTRL) && (i_data_one == SUSTAIN_CC);
        sus_on   = is_sus && (i_data_two >= r_thr);
        sus_off  = is_sus && !sus_on;
        is_off   = chan_ok && ((kind == KIND_NOTE_OFF)
                   || ((kind == KIND_NOTE_ON) && (i_data_two == '0)));
        cur_cnt  = r_count[ch];
        full     = (cur_cnt == CNT_W'(HOLD_DEPTH));
        held_off = is_off && r_pedal[ch];
        do_hold  = held_off && !full;
        do_drain = sus_off && (cur_cnt != '0);
        emit     = !sus_on && !(sus_off && (cur_cnt == '0)) && !do_hold;
    end

    // hold-store writes wait until every pending release has been read out
    assign o_ready  = !i_q_full && !(do_hold && (r_pending != '0));
    assign accept   = i_valid && o_ready;
    assign o_q_push = accept && emit;

    always_comb begin
        o_q_cmd.kind     = do_drain ? CMD_DRAIN : CMD_PASS;
        o_q_cmd.status   = i_status;
        o_q_cmd.data_one = i_data_one;
        o_q_cmd.data_two = i_data_two;
        o_q_cmd.tick     = i_tick;
        o_q_cmd.ovf      = held_off && full;
        o_q_cmd.count    = cur_cnt;
        o_q_cmd.ch       = ch;
    end

    assign o_st_we    = accept && do_hold;
    assign o_st_addr  = store_addr(ch, cur_cnt[IDX_W-1:0]);
    assign o_st_wdata = {i_status, i_data_one, i_data_two};

    // count of releases queued or in progress
    always_comb begin
        n_pending = r_pending;
        if ((accept && do_drain) && !i_drain_done) begin
            n_pending = r_pending + 1'b1;
        end else if (!(accept && do_drain) && i_drain_done) begin
            n_pending = r_pending - 1'b1;
        end
    end

    assign o_pending = r_pending;

    // threshold, pedal flags, hold counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= THR_RESET;
            r_pedal   <= '0;
            r_pending <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            r_pending <= n_pending;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (accept) begin
                if (sus_on) begin
                    r_pedal[ch] <= 1'b1;
                end
                if (sus_off) begin
                    r_pedal[ch] <= 1'b0;
                    r_count[ch] <= '0;
                end
                if (do_hold) begin
                    r_count[ch] <= cur_cnt + 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/core/spne_queue.sv -----
module spne_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  spne_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output spne_pkg::t_cmd o_cmd,
    output logic           o_empty
);
    import spne_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/spne_back.sv -----
module spne_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  spne_pkg::t_cmd                i_q_cmd,
    output logic                          o_q_pop,
    output logic [spne_pkg::ADDR_W-1:0]   o_rd_addr,
    input  logic [spne_pkg::ENTRY_W-1:0]  i_rd_data,
    output logic                          o_drain_done,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [spne_pkg::STATUS_W-1:0] o_status,
    output logic [spne_pkg::DATA_W-1:0]   o_data_one,
    output logic [spne_pkg::DATA_W-1:0]   o_data_two,
    output logic [spne_pkg::TICK_W-1:0]   o_tick,
    output logic                          o_ovf,
    output logic                          o_last
);
    import spne_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    logic [CH_W-1:0]   r_ch;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_idx;
    logic [TICK_W-1:0] r_tick;

    logic                r_ovalid;
    logic [STATUS_W-1:0] r_ostatus;
    logic [DATA_W-1:0]   r_od1;
    logic [DATA_W-1:0]   r_od2;
    logic [TICK_W-1:0]   r_otick;
    logic                r_oovf;
    logic                r_olast;

    logic out_free;
    logic load_pass;
    logic load_ent;
    logic start_drain;
    logic ent_last;

    assign out_free  = !r_ovalid || i_ready;
    assign ent_last  = (CNT_W'(r_idx + 1'b1) == r_n);
    assign o_rd_addr = store_addr(r_ch, r_idx[IDX_W-1:0]);

    // next state and control
    always_comb begin
        n_state      = r_state;
        o_q_pop      = 1'b0;
        load_pass    = 1'b0;
        load_ent     = 1'b0;
        start_drain  = 1'b0;
        o_drain_done = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_cmd.kind == CMD_DRAIN) begin
                        o_q_pop     = 1'b1;
                        start_drain = 1'b1;
                        n_state     = BK_READ;
                    end else if (out_free) begin
                        o_q_pop   = 1'b1;
                        load_pass = 1'b1;
                    end
                end
            end
            BK_READ: begin
                n_state = BK_DATA;
            end
            BK_DATA: begin
                if (out_free) begin
                    load_ent = 1'b1;
                    if (ent_last) begin
                        o_drain_done = 1'b1;
                        n_state      = BK_IDLE;
                    end else begin
                        n_state = BK_READ;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // release context
    always_ff @(posedge i_clk) begin
        if (start_drain) begin
            r_ch   <= i_q_cmd.ch;
            r_n    <= i_q_cmd.count;
            r_tick <= i_q_cmd.tick;
            r_idx  <= '0;
        end else if (load_ent && !ent_last) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_pass || load_ent) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_pass) begin
            r_ostatus <= i_q_cmd.status;
            r_od1     <= i_q_cmd.data_one;
            r_od2     <= i_q_cmd.data_two;
            r_otick   <= i_q_cmd.tick;
            r_oovf    <= i_q_cmd.ovf;
            r_olast   <= 1'b1;
        end else if (load_ent) begin
            r_ostatus <= i_rd_data[ENTRY_W-1 -: STATUS_W];
            r_od1     <= i_rd_data[2*DATA_W-1 -: DATA_W];
            r_od2     <= i_rd_data[DATA_W-1:0];
            r_otick   <= r_tick;
            r_oovf    <= 1'b0;
            r_olast   <= ent_last;
        end
    end

    assign o_valid    = r_ovalid;
    assign o_status   = r_ostatus;
    assign o_data_one = r_od1;
    assign o_data_two = r_od2;
    assign o_tick     = r_otick;
    assign o_ovf      = r_oovf;
    assign o_last     = r_olast;

endmodule
